@@ rtl/b85_pkg.sv @@
package b85_pkg;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	typedef enum logic [1:0] {
		ST_DATA = 2'd0,
		ST_BAD  = 2'd1,
		ST_OVF  = 2'd2,
		ST_MARK = 2'd3
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [6:0] val;
	} digit_t;

	// One decoded group or one error / marker result, queued for the back end.
	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  last_idx;   // index of the final result of this job
		status_t     status;
		logic        fin;        // frame end
	} job_t;

	// RFC 1924 alphabet lookup
	function automatic digit_t digit_of(input logic [7:0] ch);
		digit_t     d;
		logic [7:0] t;
		d.ok = 1'b1;
		t    = 8'd0;
		case (ch) inside
			[8'h30:8'h39]: t = ch - 8'd48;
			[8'h41:8'h5A]: t = ch - 8'd55;
			[8'h61:8'h7A]: t = ch - 8'd61;
			8'h21: t = 8'd62;
			8'h23: t = 8'd63;
			8'h24: t = 8'd64;
			8'h25: t = 8'd65;
			8'h26: t = 8'd66;
			8'h28: t = 8'd67;
			8'h29: t = 8'd68;
			8'h2A: t = 8'd69;
			8'h2B: t = 8'd70;
			8'h2D: t = 8'd71;
			8'h3B: t = 8'd72;
			8'h3C: t = 8'd73;
			8'h3D: t = 8'd74;
			8'h3E: t = 8'd75;
			8'h3F: t = 8'd76;
			8'h40: t = 8'd77;
			8'h5E: t = 8'd78;
			8'h5F: t = 8'd79;
			8'h60: t = 8'd80;
			8'h7B: t = 8'd81;
			8'h7C: t = 8'd82;
			8'h7D: t = 8'd83;
			8'h7E: t = 8'd84;
			default: d.ok = 1'b0;
		endcase
		d.val = t[6:0];
		return d;
	endfunction

	// 85^(5-c): scale that pads a group of c digits with '~'
	function automatic logic [25:0] pad_scale(input logic [2:0] c);
		logic [25:0] s;
		case (c)
			3'd1:    s = 26'd52200625;
			3'd2:    s = 26'd614125;
			3'd3:    s = 26'd7225;
			3'd4:    s = 26'd85;
			default: s = 26'd1;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/b85_if.sv @@
interface b85_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       frame_end;

	modport source (output valid, output in_char, output frame_end, input ready);
	modport sink (input valid, input in_char, input frame_end, output ready);
endinterface

interface b85_data_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last_byte;

	modport source (output valid, output out_byte, output status, output last_byte,
		input ready);
	modport sink (input valid, input out_byte, input status, input last_byte,
		output ready);
endinterface

@@ rtl/b85_front.sv @@
module b85_front (
	input  logic           clk,
	input  logic           arst_n,
	b85_text_if.sink       text,
	input  logic           q_full,
	output logic           push,
	output b85_pkg::job_t  push_job
);

	logic        en;
	logic        take;
	logic [25:0] acc_q;
	logic [2:0]  cnt_q;

	b85_pkg::digit_t d;
	logic [32:0] nv;
	logic [2:0]  c_next;
	logic        close;

	logic        v_s1, bad_s1, end_s1;
	logic [2:0]  c_s1;
	logic [32:0] val_s1;

	logic        v_s2, bad_s2, end_s2;
	logic [2:0]  c_s2;
	logic [32:0] prod_s2;
	logic [58:0] prod_full;

	logic        discard_q;
	logic [32:0] padded;
	logic [2:0]  nbytes;

	// whole front moves together; holds only while a job waits in s2 and the queue is full
	assign en         = !(v_s2 && q_full);
	assign text.ready = en;
	assign take       = text.valid && en;

	always_comb begin
		d      = b85_pkg::digit_of(text.in_char);
		nv     = 33'({7'd0, acc_q} * 33'd85) + {26'd0, d.val};
		c_next = cnt_q + 3'd1;
		close  = (c_next == 3'd5) || text.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (!d.ok || close) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= nv[25:0];
				cnt_q <= c_next;
			end
		end
	end

	// s1: one event per closed group or bad character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= take && (!d.ok || close);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1 <= !d.ok;
			end_s1 <= text.frame_end;
			c_s1   <= c_next;
			val_s1 <= nv;
		end
	end

	// s2: pad with '~' as (v+1)*85^(5-c)-1; the -1 is applied at the push
	assign prod_full = ({26'd0, val_s1} + 59'd1) * {33'd0, b85_pkg::pad_scale(c_s1)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s2  <= bad_s1;
			end_s2  <= end_s1;
			c_s2    <= c_s1;
			prod_s2 <= prod_full[32:0];
		end
	end

	// job build; after an error the rest of the frame is dropped here
	always_comb begin
		padded            = prod_s2 - 33'd1;
		nbytes            = (c_s2 == 3'd5) ? 3'd4 : c_s2 - 3'd1;
		push_job.word     = '0;
		push_job.last_idx = '0;
		push_job.fin      = end_s2;
		if (bad_s2) begin
			push_job.status = b85_pkg::ST_BAD;
		end else if (padded[32]) begin
			push_job.status = b85_pkg::ST_OVF;
		end else if (nbytes == 3'd0) begin
			push_job.status = b85_pkg::ST_MARK;
		end else begin
			push_job.status   = b85_pkg::ST_DATA;
			push_job.word     = padded[31:0];
			push_job.last_idx = 2'(nbytes - 3'd1);
		end
	end

	assign push = en && v_s2 && !discard_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_q <= 1'b0;
		end else if (en && v_s2) begin
			if (discard_q) begin
				if (end_s2) begin
					discard_q <= 1'b0;
				end
			end else if (push_job.status == b85_pkg::ST_BAD ||
					push_job.status == b85_pkg::ST_OVF) begin
				discard_q <= !end_s2;
			end
		end
	end

endmodule

@@ rtl/b85_queue.sv @@
module b85_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b85_pkg::job_t  push_job,
	input  logic           pop,
	output logic           full,
	output logic           head_v,
	output b85_pkg::job_t  head
);

	b85_pkg::job_t             mem [b85_pkg::QDepth];
	logic [b85_pkg::QAw-1:0]   wp_q, rp_q;
	logic [b85_pkg::QAw:0]     cnt_q;

	assign full   = (cnt_q == (b85_pkg::QAw+1)'(b85_pkg::QDepth));
	assign head_v = (cnt_q != '0);
	assign head   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/b85_back.sv @@
module b85_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_v,
	input  b85_pkg::job_t  head,
	output logic           pop,
	b85_data_if.source     data
);

	logic       load;
	logic [1:0] idx_q;
	logic       at_last;
	logic [7:0] byte_sel;
	logic       ov_q;

	assign load    = head_v && (!ov_q || data.ready);
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	always_comb begin
		case (idx_q)
			2'd0:    byte_sel = head.word[31:24];
			2'd1:    byte_sel = head.word[23:16];
			2'd2:    byte_sel = head.word[15:8];
			default: byte_sel = head.word[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (data.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data.out_byte  <= byte_sel;
			data.status    <= head.status;
			data.last_byte <= head.fin && at_last;
		end
	end

	assign data.valid = ov_q;

endmodule

@@ rtl/base85_stream_decoder.sv @@
// channel  dir  beat                               handshake
// text     in   in_char[7:0], frame_end            valid/ready
// data     out  out_byte[7:0], status[1:0], last   valid/ready
//
// One character beat per cycle while the front is not stalled; results leave at
// one beat per cycle while data.ready holds. A closing character passes
// accumulate, pad multiply, queue and output register on the way to its first result.
// Reset clears the group accumulator, the discard flag, the job queue and
// the output valid flag; no clearing pass.
// text.ready drops only while the four-entry job queue is full and a job
// waits at the end of the front pipeline; data stalls fill that queue.
module base85_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	b85_text_if.sink    text,
	b85_data_if.source  data
);

	logic           push, pop, q_full, head_v;
	b85_pkg::job_t  push_job, head;

	// front: alphabet lookup, acc*85+digit, '~' padding, overflow check,
	// drop of the rest of a failed frame
	b85_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// decouples a group job from its byte beats
	b85_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.head_v   (head_v),
		.head     (head)
	);

	// back: one result beat per cycle while data.ready holds, MSB first
	b85_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head_v (head_v),
		.head   (head),
		.pop    (pop),
		.data   (data)
	);

endmodule
